// ----- rtl/lcb_pkg.sv -----
// ----------------------------------------------------------------------------
// lcb_pkg: shared types and constants
// Operation codes, request/response payloads and controller command/status.
// ----------------------------------------------------------------------------
package lcb_pkg;

   localparam int OP_BITS = 3;
   localparam int PAGE_W = 16;
   localparam int REQ_TAG_W = 32;
   localparam int BYTES_W = 48;
   localparam int TOTAL_W = 53;
   localparam int COUNT_W = 6;
   localparam int STAMP_W = 64;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES = 1'd1;

   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 6'd16;
   localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 48'd67108864;

   typedef enum logic [OP_BITS-1:0] {
      OP_REGISTER = 3'd0,
      OP_REMOVE = 3'd1,
      OP_CLEAR = 3'd2,
      OP_CHECK = 3'd3,
      OP_TOUCH = 3'd4,
      OP_PIN = 3'd5,
      OP_VICTIM = 3'd6,
      OP_NONE = 3'd7
   } op_type;

   typedef struct packed {
      logic [OP_BITS-1:0] operation;
      logic [PAGE_W-1:0] page;
      logic [REQ_TAG_W-1:0] request_tag;
      logic [BYTES_W-1:0] byte_size;
   } req_type;

   typedef struct packed {
      logic hit;
      logic victim_found;
      logic [PAGE_W-1:0] victim_page;
      logic [TOTAL_W-1:0] total_bytes;
      logic [COUNT_W-1:0] entry_count;
      logic table_full;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;     // capture request, clear scan state
      logic scan;     // examine one slot at the scan index
      logic finish;   // apply the operation and build the response
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_last;
   } sts_type;

endpackage

// ----- rtl/lru_cache_policy_with_byte_budget_top.sv -----
// ----------------------------------------------------------------------------
// LRU cache policy with byte budget, top level
// Holds a table of cached pages and answers one policy operation per request.
//
// Usage: a request (operation, page, tag, byte size) is a transfer on the
// req_ channel; exactly one response follows on the rsp_ channel. Requests
// are taken one at a time: req_ready is high only while no request is in
// progress. Each request runs a slot scan, which reads one slot of the table
// memory per cycle, before rsp_valid; the next request may be accepted
// the cycle after the response transfer. If the receiver stalls, the
// response holds and no request is taken. Limits are written through csr_
// (index 0 entry limit, 1 byte limit); the user must write them only while
// idle, as the block itself does not enforce it. Synchronous reset empties
// the table, clears pins, the use clock and the byte total, and restores
// the default limits; no clearing pass needed.
// ----------------------------------------------------------------------------
module lru_cache_policy_with_byte_budget_top
   import lcb_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int TAG_BITS = 32,
   parameter int PAGE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [COUNT_W-1:0] max_entries_ff;
   logic [BYTES_W-1:0] max_bytes_ff;
   cmd_type cmd;
   sts_type sts;

   // Limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_ENTRIES: max_entries_ff <= csr_data[COUNT_W-1:0];
            CSR_MAX_BYTES: max_bytes_ff <= csr_data[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   lcb_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts)
   );

   lcb_datapath #(
      .ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS), .PAGE_BITS(PAGE_BITS)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_data(req_data), .max_entries(max_entries_ff),
      .max_bytes(max_bytes_ff), .rsp_data(rsp_data)
   );

endmodule

// ----- rtl/lcb_datapath.sv -----
// ----------------------------------------------------------------------------
// lcb_datapath: slot table, scan unit and update logic
// Scans one slot a cycle to locate the page, a free slot and the victim,
// then applies the operation and keeps the running byte total and count.
// ----------------------------------------------------------------------------
module lcb_datapath
   import lcb_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int TAG_BITS = 32,
   parameter int PAGE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   input  logic [COUNT_W-1:0] max_entries,
   input  logic [BYTES_W-1:0] max_bytes,
   output rsp_type rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Slot storage; payload arrays live in a memory read by the scan index.
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] pin_ff, pin_in;
   logic [PAGE_BITS-1:0] page_mem [ENTRIES];
   logic [TAG_BITS-1:0] tag_mem [ENTRIES];
   logic [BYTES_W-1:0] bytes_mem [ENTRIES];
   logic [STAMP_W-1:0] stamp_mem [ENTRIES];

   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Captured request.
   op_type op_ff;
   logic [PAGE_BITS-1:0] pg_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [BYTES_W-1:0] size_ff;

   // Scan state.
   logic [IDX_W-1:0] idx_ff;
   logic rd_ok_ff;                    // read data below belongs to rd_idx_ff
   logic [IDX_W-1:0] rd_idx_ff;
   logic [PAGE_BITS-1:0] rd_page_ff;
   logic [TAG_BITS-1:0] rd_tag_ff;
   logic [BYTES_W-1:0] rd_bytes_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   logic found_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic [TAG_BITS-1:0] found_tag_ff;
   logic [BYTES_W-1:0] found_bytes_ff;
   logic free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic vic_ff;
   logic [PAGE_BITS-1:0] vic_page_ff;
   logic [STAMP_W-1:0] vic_stamp_ff;
   logic need_prune_ff;

   rsp_type rsp_ff, rsp_in;

   assign sts.scan_last = (idx_ff == IDX_W'(ENTRIES - 1));
   assign rsp_data = rsp_ff;

   // Memory read, registered, one slot per cycle.
   always_ff @(posedge clock) begin
      rd_page_ff <= page_mem[idx_ff];
      rd_tag_ff <= tag_mem[idx_ff];
      rd_bytes_ff <= bytes_mem[idx_ff];
      rd_stamp_ff <= stamp_mem[idx_ff];
      rd_idx_ff <= idx_ff;
   end

   // Evaluation of the slot whose data has just been read.
   logic ev_valid, ev_match, ev_older;
   always_comb begin
      ev_valid = rd_ok_ff && valid_ff[rd_idx_ff];
      ev_match = ev_valid && (rd_page_ff == pg_ff);
      ev_older = (rd_stamp_ff < vic_stamp_ff) ||
                 (vic_ff && rd_stamp_ff == vic_stamp_ff && rd_page_ff < vic_page_ff);
   end

   // Scan control and find registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else if (cmd.load) begin
         idx_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= sts.scan_last ? idx_ff : idx_ff + 1'b1;
         rd_ok_ff <= 1'b1;
      end else begin
         rd_ok_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_data.operation);
         pg_ff <= req_data.page[PAGE_BITS-1:0];
         tag_ff <= req_data.request_tag[TAG_BITS-1:0];
         size_ff <= req_data.byte_size;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
         vic_ff <= 1'b0;
         vic_stamp_ff <= '1;
         vic_page_ff <= '0;
         need_prune_ff <= (32'(count_ff) > 32'(max_entries)) ||
                          (total_ff > TOTAL_W'(max_bytes));
      end else if (rd_ok_ff) begin
         if (ev_match && !found_ff) begin
            found_ff <= 1'b1;
            found_idx_ff <= rd_idx_ff;
            found_tag_ff <= rd_tag_ff;
            found_bytes_ff <= rd_bytes_ff;
         end
         if (!ev_valid && !free_ff) begin
            free_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (ev_valid && !pin_ff[rd_idx_ff] && ev_older) begin
            vic_ff <= 1'b1;
            vic_stamp_ff <= rd_stamp_ff;
            vic_page_ff <= rd_page_ff;
         end
      end
   end

   // Apply the operation.
   logic wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic wr_new;
   logic [STAMP_W-1:0] clk_next;
   logic [TOTAL_W:0] sum_add;
   logic tag_eq;
   always_comb begin
      valid_in = valid_ff;
      pin_in = pin_ff;
      clock_in = clock_ff;
      total_in = total_ff;
      count_in = count_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_new = 1'b0;
      wr_idx = found_ff ? found_idx_ff : free_idx_ff;
      clk_next = clock_ff + 1'b1;
      tag_eq = found_ff && (found_tag_ff == tag_ff);
      sum_add = '0;
      if (cmd.finish) begin
         rsp_in = '0;
         unique case (op_ff)
            OP_REGISTER: begin
               if (!found_ff && !free_ff) begin
                  rsp_in.table_full = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  wr_new = !found_ff;
                  clock_in = clk_next;
                  if (found_ff) begin
                     sum_add = {1'b0, total_ff - TOTAL_W'(found_bytes_ff)} +
                               (TOTAL_W + 1)'(size_ff);
                  end else begin
                     sum_add = {1'b0, total_ff} + (TOTAL_W + 1)'(size_ff);
                     valid_in[free_idx_ff] = 1'b1;
                     pin_in[free_idx_ff] = 1'b0;
                     count_in = count_ff + 1'b1;
                  end
                  total_in = sum_add[TOTAL_W] ? '1 : sum_add[TOTAL_W-1:0];
               end
            end
            OP_REMOVE: begin
               if (found_ff) begin
                  valid_in[found_idx_ff] = 1'b0;
                  pin_in[found_idx_ff] = 1'b0;
                  total_in = total_ff - TOTAL_W'(found_bytes_ff);
                  count_in = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               valid_in = '0;
               pin_in = '0;
               total_in = '0;
               count_in = '0;
            end
            OP_CHECK: rsp_in.hit = tag_eq;
            OP_TOUCH: begin
               if (tag_eq) begin
                  rsp_in.hit = 1'b1;
                  wr_en = 1'b1;
                  clock_in = clk_next;
               end
            end
            OP_PIN: begin
               if (found_ff) pin_in[found_idx_ff] = 1'b1;
            end
            OP_VICTIM: begin
               pin_in = '0;
               if (need_prune_ff && vic_ff) begin
                  rsp_in.victim_found = 1'b1;
                  rsp_in.victim_page = PAGE_W'(vic_page_ff);
               end
            end
            default: ;
         endcase
         rsp_in.total_bytes = total_in;
         rsp_in.entry_count = COUNT_W'(count_in);
      end
   end

   // Memory writes.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[wr_idx] <= clk_next;
         if (op_ff == OP_REGISTER) begin
            tag_mem[wr_idx] <= tag_ff;
            bytes_mem[wr_idx] <= size_ff;
            if (wr_new) page_mem[wr_idx] <= pg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pin_ff <= '0;
         clock_ff <= '0;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         pin_ff <= pin_in;
         clock_ff <= clock_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/lcb_control.sv -----
// ----------------------------------------------------------------------------
// lcb_control: operation sequencer
// Accepts a request, runs the slot scan, applies the operation and holds the
// response until it is taken.
// ----------------------------------------------------------------------------
module lcb_control
   import lcb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_APPLY = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_APPLY;
         ST_APPLY: begin
            cmd.finish = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/lcb_checker.sv -----
// ----------------------------------------------------------------------------
// lcb_checker: port-level checks
// Watches the top-level handshakes and response fields over time.
// ----------------------------------------------------------------------------
module lcb_checker
   import lcb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);

   // A request transfer is never taken while a response waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");

   // After a request transfer, the block is busy in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after request");

   // Only one flag group is raised per response.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.hit, rsp_data.victim_found,
                                rsp_data.table_full}) <= 1)
      else $error("conflicting response flags");

endmodule

bind lru_cache_policy_with_byte_budget_top lcb_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
